// File: hdl/msort_pkg.sv
// ---------------------------------------------------------------------------
// msort_pkg: shared constants and types for the signed merge sorter
// Store geometry, index widths and the sequencer state encoding.
// ---------------------------------------------------------------------------
package msort_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Write side of one store bank.
  typedef struct packed {
    logic   en;
    addr_t  addr;
    value_t data;
  } wr_port_t;

  // Dual-address read request to one store bank.
  typedef struct packed {
    logic  en;
    addr_t addr_a;
    addr_t addr_b;
  } rd_req_t;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RUN  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_ORD  = 6'b010000,
    ST_OWR  = 6'b100000
  } state_e;

endpackage

// File: hdl/merge_sort_signed.sv
// ---------------------------------------------------------------------------
// merge_sort_signed: stable ascending sort of one set of signed values
// Loads a set into a store bank, merge-sorts it between two banks, streams
// the sorted set out.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one signed value per beat on s_axis_tdata_i; the beat with
//   s_axis_tlast_i high closes the set. Up to MAX_ELEMENTS values are kept;
//   later ones are dropped and every result of that set has tuser high.
//   Output stream: the sorted values, lowest first, tlast on the final one.
// Flow:
//   Load writes each kept beat to bank 0. The sort runs ceil(log2(n))
//   passes; for each element a pass issues a dual-port bank read of both
//   run heads, then compares and writes the winner to the other bank, and
//   each run pair starts with a setup step. Output reads the bank, then
//   loads the output register, per element; the registered bank read is
//   why each element needs a read step before it is used.
//   s_axis_tready_o is high only while loading, so a set is taken as a whole
//   once the previous one has left the banks.
// Reset: clears the sequencer, element count, overflow flag, output valid;
//   bank contents are not cleared, only entries of the current set are used.
// Stall: a held output beat stops the output sequencer; nothing is lost.
// ---------------------------------------------------------------------------
module merge_sort_signed
  import msort_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   s_axis_tvalid_i,
  output logic   s_axis_tready_o,
  input  value_t s_axis_tdata_i,   // [31:0] value
  input  logic   s_axis_tlast_i,   // last
  output logic   m_axis_tvalid_o,
  input  logic   m_axis_tready_i,
  output value_t m_axis_tdata_o,   // [31:0] sorted_value
  output logic   m_axis_tlast_o,   // end_of_set
  output logic   m_axis_tuser_o    // [0] overflowed
);

  localparam cnt_t CNT_ONE = CNT_W'(1);
  localparam cnt_t CNT_MAX = CNT_W'(MAX_ELEMENTS);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;   // elements stored in this set
  logic   ovf_q, ovf_d;
  cnt_t   n_q, n_d;           // size of the closed set
  cnt_t   w_q, w_d;           // run width of the current pass
  cnt_t   k_q, k_d;           // destination index / output index
  cnt_t   a_q, a_d, b_q, b_d; // heads of left and right runs
  cnt_t   mid_q, mid_d, hi_q, hi_d;
  logic   src_q, src_d;       // bank holding the current data

  logic   out_valid_q, out_valid_d;
  value_t out_data_q, out_data_d;
  logic   out_last_q, out_last_d;
  logic   out_ovf_q, out_ovf_d;

  wr_port_t wr0, wr1, wr_sort;
  rd_req_t  rd0, rd1, rd_req;
  value_t   ra0, rb0, ra1, rb1, ra, rb;

  logic          in_beat, out_load, take_a, room;
  logic [CNT_W:0] sum_mid, sum_hi;
  cnt_t          k_inc, n_new;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign room    = count_q < CNT_MAX;
  assign k_inc   = k_q + CNT_ONE;
  assign n_new   = room ? count_q + CNT_ONE : count_q;
  assign sum_mid = {1'b0, k_q} + {1'b0, w_q};
  assign sum_hi  = {1'b0, k_q} + {w_q, 1'b0};

  // Current bank read data.
  assign ra = src_q ? ra1 : ra0;
  assign rb = src_q ? rb1 : rb0;

  // Left run wins ties, which keeps the sort stable.
  assign take_a = (a_q < mid_q) &&
                  ((b_q >= hi_q) || ($signed(ra) <= $signed(rb)));

  assign out_load = (state_q == ST_OWR) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    rd_req.en     = (state_q == ST_RD) || (state_q == ST_ORD);
    rd_req.addr_a = (state_q == ST_ORD) ? k_q[ADDR_W-1:0] : a_q[ADDR_W-1:0];
    rd_req.addr_b = b_q[ADDR_W-1:0];
    rd0           = rd_req;
    rd1           = rd_req;
    rd0.en        = rd_req.en && !src_q;
    rd1.en        = rd_req.en && src_q;

    wr_sort.en    = (state_q == ST_CMP);
    wr_sort.addr  = k_q[ADDR_W-1:0];
    wr_sort.data  = take_a ? ra : rb;

    // Loading always fills bank 0; merges write the bank not being read.
    if (state_q == ST_LOAD) begin
      wr0.en   = in_beat && room;
      wr0.addr = count_q[ADDR_W-1:0];
      wr0.data = s_axis_tdata_i;
    end else begin
      wr0    = wr_sort;
      wr0.en = wr_sort.en && src_q;
    end
    wr1    = wr_sort;
    wr1.en = wr_sort.en && !src_q;
  end

  msort_ram u_bank0 (
    .clk_i     (clk_i),
    .wr_i      (wr0),
    .rd_i      (rd0),
    .rdata_a_o (ra0),
    .rdata_b_o (rb0)
  );

  msort_ram u_bank1 (
    .clk_i     (clk_i),
    .wr_i      (wr1),
    .rd_i      (rd1),
    .rdata_a_o (ra1),
    .rdata_b_o (rb1)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    n_d     = n_q;
    w_d     = w_q;
    k_d     = k_q;
    a_d     = a_q;
    b_d     = b_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    src_d   = src_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (room) begin
            count_d = count_q + CNT_ONE;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            n_d     = n_new;
            w_d     = CNT_ONE;
            k_d     = '0;
            src_d   = 1'b0;
            state_d = (n_new > CNT_ONE) ? ST_RUN : ST_ORD;
          end
        end
      end
      ST_RUN: begin
        // Bounds of the next run pair, clipped to the set size.
        a_d     = k_q;
        mid_d   = (sum_mid > {1'b0, n_q}) ? n_q : sum_mid[CNT_W-1:0];
        hi_d    = (sum_hi > {1'b0, n_q}) ? n_q : sum_hi[CNT_W-1:0];
        b_d     = (sum_mid > {1'b0, n_q}) ? n_q : sum_mid[CNT_W-1:0];
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (take_a) begin
          a_d = a_q + CNT_ONE;
        end else begin
          b_d = b_q + CNT_ONE;
        end
        k_d = k_inc;
        if (k_inc == n_q) begin
          w_d   = {w_q[CNT_W-2:0], 1'b0};
          src_d = !src_q;
          k_d   = '0;
          state_d = ({w_q, 1'b0} >= {1'b0, n_q}) ? ST_ORD : ST_RUN;
        end else if (k_inc == hi_q) begin
          state_d = ST_RUN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_ORD: begin
        state_d = ST_OWR;
      end
      ST_OWR: begin
        if (out_load) begin
          if (k_inc == n_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            src_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_inc;
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Output register; holds a beat while the sink stalls.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = ra;
      out_last_d  = (k_inc == n_q);
      out_ovf_d   = ovf_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    w_q        <= w_d;
    k_q        <= k_d;
    a_q        <= a_d;
    b_q        <= b_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("element count above store depth");

  a_merge_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> (a_q < mid_q) || (b_q < hi_q))
    else $error("merge step with both runs empty");

  a_width_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_RD || state_q == ST_CMP) |-> $onehot(w_q))
    else $error("run width not a power of two");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_inc == n_q) |=> (count_q == '0) && !ovf_q && s_axis_tready_o)
    else $error("set state not cleared after final beat");

  a_no_load_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("output register overwritten");
`endif

endmodule

// File: hdl/msort_ram.sv
// ---------------------------------------------------------------------------
// msort_ram: one store bank
// One write port, two synchronous read ports sharing an enable; read data
// is registered and holds while no read is issued.
// ---------------------------------------------------------------------------
module msort_ram
  import msort_pkg::*;
(
  input  logic     clk_i,
  input  wr_port_t wr_i,
  input  rd_req_t  rd_i,
  output value_t   rdata_a_o,
  output value_t   rdata_b_o
);

  value_t mem_q [MAX_ELEMENTS];
  value_t rdata_a_q;
  value_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_a_q <= mem_q[rd_i.addr_a];
      rdata_b_q <= mem_q[rd_i.addr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
